// ===== rtl/core/mts_pkg.sv =====
// Package for the melody tone sequencer: command and melody codes, field widths,
// the fixed note table and the control/status structs between controller and datapath.
// Depends on nothing.
package mts_pkg;

   // Command codes
   localparam logic [1:0] CMD_TICK = 2'd0;
   localparam logic [1:0] CMD_PLAY = 2'd1;
   localparam logic [1:0] CMD_STOP = 2'd2;
   localparam logic [1:0] CMD_BEEP = 2'd3;

   // Melody codes; anything above the custom slot is no melody
   localparam logic [2:0] MEL_BOOT       = 3'd0;
   localparam logic [2:0] MEL_ALERT      = 3'd1;
   localparam logic [2:0] MEL_ALERT_FAST = 3'd2;
   localparam logic [2:0] MEL_WARNING    = 3'd3;
   localparam logic [2:0] MEL_BEGIN      = 3'd4;
   localparam logic [2:0] MEL_CUSTOM     = 3'd5;

   // Field widths
   localparam int CMD_W      = 2;
   localparam int MEL_W      = 3;
   localparam int IDX_W      = 3;
   localparam int FREQ_W     = 16;
   localparam int BEEP_DUR_W = 16;
   localparam int CLK_W      = 28;
   localparam int PRE_W      = 21;
   localparam int ROM_MS_W   = 9;

   // Prescale arithmetic: clock / (freq * 100)
   localparam int SCALE_W = 7;
   localparam logic [SCALE_W-1:0] PRESCALE_SCALE = 7'd100;
   localparam int DIVR_W    = FREQ_W + SCALE_W;
   localparam int DIV_STEPS = CLK_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);
   localparam logic [CLK_W-1:0] CLK_RESET   = 28'd72000000;
   localparam logic [PRE_W-1:0] PRESCALE_MAX = '1;

   typedef struct packed {
      logic [FREQ_W-1:0]   hz;
      logic [ROM_MS_W-1:0] ms;
   } rom_note_type;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;   // latch the input word
      logic execute;   // apply the command to the player state
      logic prep;      // set up the prescale divider
      logic step;      // one divider iteration
      logic load;      // move the result into the output register
   } mts_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic div_last;  // current divider iteration is the last one
   } mts_status_type;

   // Fixed melodies; a zero/zero note terminates
   function automatic rom_note_type note_rom(input logic [MEL_W-1:0] mel,
                                             input logic [IDX_W-1:0] idx);
      rom_note_type n;
      n = '0;
      case (mel)
         MEL_BOOT: begin
            case (idx)
               3'd0:    n = '{16'd523, 9'd100};
               3'd1:    n = '{16'd659, 9'd175};
               3'd2:    n = '{16'd523, 9'd100};
               3'd3:    n = '{16'd698, 9'd150};
               3'd4:    n = '{16'd659, 9'd80};
               default: n = '0;
            endcase
         end
         MEL_ALERT: begin
            case (idx)
               3'd0:    n = '{16'd2000, 9'd200};
               3'd1:    n = '{16'd200, 9'd200};
               3'd2:    n = '{16'd2000, 9'd200};
               3'd3:    n = '{16'd200, 9'd200};
               default: n = '0;
            endcase
         end
         MEL_ALERT_FAST: begin
            case (idx)
               3'd0:    n = '{16'd2000, 9'd100};
               3'd1:    n = '{16'd200, 9'd100};
               3'd2:    n = '{16'd2000, 9'd100};
               3'd3:    n = '{16'd200, 9'd100};
               default: n = '0;
            endcase
         end
         MEL_WARNING: begin
            case (idx)
               3'd0:    n = '{16'd800, 9'd200};
               3'd1:    n = '{16'd400, 9'd200};
               3'd2:    n = '{16'd200, 9'd0};
               3'd3:    n = '{16'd200, 9'd400};
               default: n = '0;
            endcase
         end
         MEL_BEGIN: begin
            case (idx)
               3'd0:    n = '{16'd800, 9'd200};
               3'd1:    n = '{16'd0, 9'd200};
               3'd2:    n = '{16'd800, 9'd200};
               default: n = '0;
            endcase
         end
         default: n = '0;
      endcase
      return n;
   endfunction

endpackage

// ===== rtl/core/mts_ctrl.sv =====
// Controller for the melody tone sequencer: sequences capture, execute, divider
// and output load, and owns the output valid flag. Depends on mts_pkg.
module mts_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  mts_pkg::mts_status_type status,
   output mts_pkg::mts_cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_EXEC = 3'd1;
   localparam logic [2:0] ST_PREP = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_LOAD = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       out_valid_ff, out_valid_in;
   logic       load_ok;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = out_valid_ff;
   assign load_ok   = !out_valid_ff || rsp_ready;

   // Decode state into datapath commands
   always_comb begin
      cmd         = '0;
      cmd.capture = req_valid && req_ready;
      cmd.execute = (state_ff == ST_EXEC);
      cmd.prep    = (state_ff == ST_PREP);
      cmd.step    = (state_ff == ST_DIV);
      cmd.load    = (state_ff == ST_LOAD) && load_ok;
   end

   // Advance the sequence
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_EXEC;
         ST_EXEC: state_in = ST_PREP;
         ST_PREP: state_in = ST_DIV;
         ST_DIV:  if (status.div_last) state_in = ST_LOAD;
         ST_LOAD: if (load_ok) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Hold the result word until taken
   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

// ===== rtl/core/mts_datapath.sv =====
// Datapath for the melody tone sequencer: player state, note lookup, the
// restoring prescale divider and the output register. Depends on mts_pkg.
module mts_datapath #(
   parameter int DURATION_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  mts_pkg::mts_cmd_type                 cmd,
   output mts_pkg::mts_status_type              status,
   input  logic                                 csr_valid,
   input  logic [mts_pkg::CLK_W-1:0]            csr_timer_clock_hz,
   input  logic [mts_pkg::CMD_W-1:0]            req_command,
   input  logic [mts_pkg::MEL_W-1:0]            req_melody_number,
   input  logic                                 req_repeat_flag,
   input  logic [mts_pkg::FREQ_W-1:0]           req_beep_freq,
   input  logic [mts_pkg::BEEP_DUR_W-1:0]       req_beep_duration,
   input  logic                                 req_battery_fault,
   output logic [mts_pkg::FREQ_W-1:0]           rsp_tone_freq,
   output logic [mts_pkg::PRE_W-1:0]            rsp_prescale,
   output logic                                 rsp_playing
);

   typedef struct packed {
      logic [mts_pkg::FREQ_W-1:0] hz;
      logic [DURATION_WIDTH-1:0]  ms;
   } note_type;

   // Look up a note, custom slot included
   function automatic note_type fetch(input logic [mts_pkg::MEL_W-1:0] mel,
                                      input logic [mts_pkg::IDX_W-1:0] idx,
                                      input logic [mts_pkg::FREQ_W-1:0] c_hz,
                                      input logic [DURATION_WIDTH-1:0] c_ms);
      note_type              n;
      mts_pkg::rom_note_type r;
      r = mts_pkg::note_rom(mel, idx);
      n = '0;
      if (mel == mts_pkg::MEL_CUSTOM) begin
         if (idx == '0) begin
            n.hz = c_hz;
            n.ms = c_ms;
         end
      end else if (mel < mts_pkg::MEL_CUSTOM) begin
         n.hz = r.hz;
         n.ms = DURATION_WIDTH'(r.ms);
      end
      return n;
   endfunction

   // Configuration
   logic [mts_pkg::CLK_W-1:0] clock_hz_ff;

   // Captured input word
   logic [mts_pkg::CMD_W-1:0]      item_cmd_ff;
   logic [mts_pkg::MEL_W-1:0]      item_mel_ff;
   logic                           item_rep_ff;
   logic [mts_pkg::FREQ_W-1:0]     item_bfreq_ff;
   logic [mts_pkg::BEEP_DUR_W-1:0] item_bdur_ff;
   logic                           item_fault_ff;

   // Player state
   logic                       active_ff, active_in;
   logic [mts_pkg::MEL_W-1:0]  melody_ff, melody_in;
   logic [mts_pkg::IDX_W-1:0]  index_ff, index_in;
   logic                       repeat_ff, repeat_in;
   logic [DURATION_WIDTH-1:0]  elapsed_ff, elapsed_in;
   logic [mts_pkg::FREQ_W-1:0] cust_hz_ff, cust_hz_in;
   logic [DURATION_WIDTH-1:0]  cust_ms_ff, cust_ms_in;
   logic [mts_pkg::FREQ_W-1:0] freq_ff, freq_in;

   // Divider
   logic [mts_pkg::DIVR_W-1:0] divisor_ff;
   logic [mts_pkg::DIVR_W-1:0] rem_ff;
   logic [mts_pkg::CLK_W-1:0]  quot_ff;
   logic                       zero_ff;
   logic [mts_pkg::CNT_W-1:0]  count_ff;
   logic [mts_pkg::DIVR_W:0]   rem_sh;
   logic                       rem_ge;

   // Execute helpers
   logic                       is_start;
   logic                       blocked;
   logic [mts_pkg::MEL_W-1:0]  start_mel;
   logic                       start_rep;
   logic [mts_pkg::FREQ_W-1:0] c_hz;
   logic [DURATION_WIDTH-1:0]  c_ms;
   logic [mts_pkg::MEL_W-1:0]  ent_mel;
   logic [mts_pkg::IDX_W-1:0]  ent_idx;
   logic                       ent_rep;
   note_type                   cur_note;
   note_type                   first_note;
   note_type                   head_note;
   logic [mts_pkg::FREQ_W-1:0] e_freq;
   logic [mts_pkg::IDX_W-1:0]  e_idx;
   logic                       e_active;

   // Take configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         clock_hz_ff <= mts_pkg::CLK_RESET;
      end else if (csr_valid) begin
         clock_hz_ff <= csr_timer_clock_hz;
      end
   end

   // Latch the input word
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_cmd_ff   <= req_command;
         item_mel_ff   <= req_melody_number;
         item_rep_ff   <= req_repeat_flag;
         item_bfreq_ff <= req_beep_freq;
         item_bdur_ff  <= req_beep_duration;
         item_fault_ff <= req_battery_fault;
      end
   end

   // Select the melody and note to enter
   always_comb begin
      is_start  = (item_cmd_ff == mts_pkg::CMD_PLAY) || (item_cmd_ff == mts_pkg::CMD_BEEP);
      start_mel = (item_cmd_ff == mts_pkg::CMD_BEEP) ? mts_pkg::MEL_CUSTOM : item_mel_ff;
      start_rep = (item_cmd_ff == mts_pkg::CMD_BEEP) ? 1'b0 : item_rep_ff;
      c_hz      = (item_cmd_ff == mts_pkg::CMD_BEEP) ? item_bfreq_ff : cust_hz_ff;
      c_ms      = (item_cmd_ff == mts_pkg::CMD_BEEP) ? DURATION_WIDTH'(item_bdur_ff)
                                                     : cust_ms_ff;
      blocked   = item_fault_ff && (start_mel != mts_pkg::MEL_ALERT)
                  && (start_mel != mts_pkg::MEL_ALERT_FAST);
      ent_mel   = is_start ? start_mel : melody_ff;
      ent_idx   = is_start ? '0 : mts_pkg::IDX_W'(index_ff + 1'b1);
      ent_rep   = is_start ? start_rep : repeat_ff;
      cur_note   = fetch(melody_ff, index_ff, cust_hz_ff, cust_ms_ff);
      first_note = fetch(ent_mel, ent_idx, c_hz, c_ms);
      head_note  = fetch(ent_mel, '0, c_hz, c_ms);
   end

   // Enter a note; on a terminator either loop to the head or drop play
   always_comb begin
      e_freq   = first_note.hz;
      e_idx    = ent_idx;
      e_active = 1'b1;
      if (first_note == '0) begin
         e_active = 1'b0;
         if (ent_rep && (ent_idx != '0) && (head_note != '0)) begin
            e_freq   = head_note.hz;
            e_idx    = '0;
            e_active = 1'b1;
         end
      end
   end

   // Apply the command
   always_comb begin
      active_in  = active_ff;
      melody_in  = melody_ff;
      index_in   = index_ff;
      repeat_in  = repeat_ff;
      elapsed_in = elapsed_ff;
      cust_hz_in = cust_hz_ff;
      cust_ms_in = cust_ms_ff;
      freq_in    = freq_ff;
      if (cmd.execute) begin
         case (item_cmd_ff) inside
            mts_pkg::CMD_TICK: begin
               if (active_ff) begin
                  if (elapsed_ff >= cur_note.ms) begin
                     freq_in    = e_freq;
                     index_in   = e_idx;
                     elapsed_in = '0;
                     active_in  = e_active;
                  end else begin
                     elapsed_in = DURATION_WIDTH'(elapsed_ff + 1'b1);
                  end
               end
            end
            mts_pkg::CMD_PLAY, mts_pkg::CMD_BEEP: begin
               if (item_cmd_ff == mts_pkg::CMD_BEEP) begin
                  cust_hz_in = c_hz;
                  cust_ms_in = c_ms;
               end
               if (!blocked) begin
                  if (start_mel > mts_pkg::MEL_CUSTOM) begin
                     active_in = 1'b0;
                  end else begin
                     melody_in  = start_mel;
                     repeat_in  = start_rep;
                     freq_in    = e_freq;
                     index_in   = e_idx;
                     elapsed_in = '0;
                     active_in  = e_active;
                  end
               end
            end
            mts_pkg::CMD_STOP: begin
               if (!item_fault_ff) begin
                  freq_in   = '0;
                  active_in = 1'b0;
                  repeat_in = 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= 1'b0;
         melody_ff  <= '0;
         index_ff   <= '0;
         repeat_ff  <= 1'b0;
         elapsed_ff <= '0;
         cust_hz_ff <= '0;
         cust_ms_ff <= '0;
         freq_ff    <= '0;
      end else begin
         active_ff  <= active_in;
         melody_ff  <= melody_in;
         index_ff   <= index_in;
         repeat_ff  <= repeat_in;
         elapsed_ff <= elapsed_in;
         cust_hz_ff <= cust_hz_in;
         cust_ms_ff <= cust_ms_in;
         freq_ff    <= freq_in;
      end
   end

   // Restoring divider, one quotient bit a cycle
   assign rem_sh = {rem_ff, quot_ff[mts_pkg::CLK_W-1]};
   assign rem_ge = (rem_sh >= {1'b0, divisor_ff});
   assign status.div_last = (count_ff == mts_pkg::CNT_W'(mts_pkg::DIV_STEPS - 1));

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         divisor_ff <= {{(mts_pkg::DIVR_W-mts_pkg::FREQ_W){1'b0}}, freq_ff}
                       * mts_pkg::DIVR_W'(mts_pkg::PRESCALE_SCALE);
         rem_ff     <= '0;
         quot_ff    <= clock_hz_ff;
         zero_ff    <= (freq_ff == '0);
         count_ff   <= '0;
      end else if (cmd.step) begin
         rem_ff   <= rem_ge ? mts_pkg::DIVR_W'(rem_sh - {1'b0, divisor_ff})
                            : rem_sh[mts_pkg::DIVR_W-1:0];
         quot_ff  <= {quot_ff[mts_pkg::CLK_W-2:0], rem_ge};
         count_ff <= mts_pkg::CNT_W'(count_ff + 1'b1);
      end
   end

   // Load the result word, saturating the prescale
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_tone_freq <= freq_ff;
         rsp_playing   <= active_ff;
         if (zero_ff) begin
            rsp_prescale <= '0;
         end else if (quot_ff > mts_pkg::CLK_W'(mts_pkg::PRESCALE_MAX)) begin
            rsp_prescale <= mts_pkg::PRESCALE_MAX;
         end else begin
            rsp_prescale <= quot_ff[mts_pkg::PRE_W-1:0];
         end
      end
   end

endmodule

// ===== rtl/core/melody_tone_sequencer_unit.sv =====
// Top level of the melody tone sequencer: command word in, tone word out.
// Instantiates mts_ctrl and mts_datapath; depends on mts_pkg.
//
//   channel  direction  carries                                   handshake
//   req_     in         command, melody, repeat, beep note, fault  req_valid/req_ready
//   rsp_     out        tone_freq, prescale, playing               rsp_valid/rsp_ready
//   csr_     in         timer_clock_hz                             csr_valid/csr_ready
//
// Each command word runs from acceptance to the next acceptance through these steps:
// apply the command, form freq*100, run the one-bit-a-cycle prescale divider and
// load the output register. Synchronous reset returns to silence and a 72 MHz timer clock.
// A stalled rsp_ channel holds the finished word; the next command is still taken
// and runs up to the load step, which waits until the output register frees.
module melody_tone_sequencer_unit #(
   parameter int DURATION_WIDTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [mts_pkg::CMD_W-1:0]      req_command,
   input  logic [mts_pkg::MEL_W-1:0]      req_melody_number,
   input  logic                           req_repeat_flag,
   input  logic [mts_pkg::FREQ_W-1:0]     req_beep_freq,
   input  logic [mts_pkg::BEEP_DUR_W-1:0] req_beep_duration,
   input  logic                           req_battery_fault,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [mts_pkg::FREQ_W-1:0]     rsp_tone_freq,
   output logic [mts_pkg::PRE_W-1:0]      rsp_prescale,
   output logic                           rsp_playing,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [mts_pkg::CLK_W-1:0]      csr_timer_clock_hz
);

   mts_pkg::mts_cmd_type    cmd;
   mts_pkg::mts_status_type status;

   // Accept register writes at any time
   assign csr_ready = 1'b1;

   mts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mts_datapath #(
      .DURATION_WIDTH (DURATION_WIDTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_valid          (csr_valid && csr_ready),
      .csr_timer_clock_hz (csr_timer_clock_hz),
      .req_command        (req_command),
      .req_melody_number  (req_melody_number),
      .req_repeat_flag    (req_repeat_flag),
      .req_beep_freq      (req_beep_freq),
      .req_beep_duration  (req_beep_duration),
      .req_battery_fault  (req_battery_fault),
      .rsp_tone_freq      (rsp_tone_freq),
      .rsp_prescale       (rsp_prescale),
      .rsp_playing        (rsp_playing)
   );

   // One command word in flight at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input taken while a command word is in flight");

   // A silent tone never carries a prescale
   a_silent_prescale: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_prescale != '0)) |-> (rsp_tone_freq != '0))
      else $error("nonzero prescale with silent tone");

   // Reset leaves no result pending and the input open
   a_reset_clean: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("result pending or input closed after reset");

endmodule
